/* hw/rtl/hierarchical_handle_table_assert.svh */
// assertion macros for the handle table
`ifndef HIERARCHICAL_HANDLE_TABLE_ASSERT_SVH
`define HIERARCHICAL_HANDLE_TABLE_ASSERT_SVH

// same-cycle implication
`define HHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/hht_pkg.sv */
// shared types and codes of the handle table
`timescale 1ns / 1ps
`default_nettype none
package hht_pkg;

  localparam int REQ_W  = 3;
  localparam int IDX_W  = 10;
  localparam int TYPE_W = 9;
  localparam int OBJ_W  = 64;
  localparam int FLAG_W = 64;
  localparam int STAT_W = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_OPEN     = 3'd0,
    REQ_USE      = 3'd1,
    REQ_RCLOSE   = 3'd2,
    REQ_COMPLETE = 3'd3,
    REQ_CLOSE    = 3'd4
  } req_code_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_CLOSING   = 3'd2,
    ST_HELD      = 3'd3,
    ST_FULL      = 3'd4,
    ST_NULL      = 3'd5
  } status_code_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RD_WAIT,
    S_EXEC,
    S_TOP,
    S_SUB,
    S_LEAF_WAIT,
    S_LEAF_CHK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic         cap;
    logic         clear_wr;
    logic         addr_req;
    logic         top_init;
    logic         top_next;
    logic         top_take;
    logic         sub_next;
    logic         sub_take;
    logic         leaf_next;
    logic         open_write;
    logic         exec;
    logic         set_code;
    status_code_t code;
    logic         emit;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_open;
    logic obj_zero;
    logic top_ok;
    logic top_last;
    logic sub_ok;
    logic sub_last;
    logic leaf_free;
    logic leaf_last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/hht_req_if.sv */
// request channel interface
`timescale 1ns / 1ps
`default_nettype none
interface hht_req_if import hht_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [IDX_W-1:0]  handle_index;
  logic [TYPE_W-1:0] type_mask;
  logic [OBJ_W-1:0]  object_ref;
  logic [FLAG_W-1:0] entry_flags;
  logic              read_only;

  modport source (output valid, req_type, handle_index, type_mask, object_ref, entry_flags,
                  read_only, input ready);
  modport sink (input valid, req_type, handle_index, type_mask, object_ref, entry_flags,
                read_only, output ready);
endinterface
`default_nettype wire

/* hw/rtl/hht_rsp_if.sv */
// response channel interface
`timescale 1ns / 1ps
`default_nettype none
interface hht_rsp_if import hht_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [IDX_W-1:0]  result_handle;
  logic [OBJ_W-1:0]  result_object;
  logic [TYPE_W-1:0] result_type;
  logic [FLAG_W-1:0] result_flags;
  logic              result_read_only;

  modport source (output valid, status, result_handle, result_object, result_type,
                  result_flags, result_read_only, input ready);
  modport sink (input valid, status, result_handle, result_object, result_type,
                result_flags, result_read_only, output ready);
endinterface
`default_nettype wire

/* hw/rtl/hierarchical_handle_table.sv */
// handle table top level
// resolve, complete and close: decode, slot read wait, execute, then the result state
// open: decode, then scans over top groups, subgroups and memory slots, then the result state
// throughput: one request at a time, a new request is taken once the result is queued
// reset: a clearing pass writes every slot and subgroup count before the first request is taken
`timescale 1ns / 1ps
`default_nettype none
module hierarchical_handle_table import hht_pkg::*; #(
  parameter int TOP_GROUPS = 8,
  parameter int SUB_GROUPS = 8,
  parameter int LEAF_SLOTS = 16,
  parameter int HOLD_BITS  = 16
) (
  input wire logic clk,
  input wire logic rst,
  hht_req_if.sink  req,
  hht_rsp_if.source rsp
);

  dp_cmd_t  cmd;
  dp_stat_t st;

  hht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  hht_dp #(
    .TOP_GROUPS (TOP_GROUPS),
    .SUB_GROUPS (SUB_GROUPS),
    .LEAF_SLOTS (LEAF_SLOTS),
    .HOLD_BITS  (HOLD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .in_req_type     (req.req_type),
    .in_handle_index (req.handle_index),
    .in_type_mask    (req.type_mask),
    .in_object_ref   (req.object_ref),
    .in_entry_flags  (req.entry_flags),
    .in_read_only    (req.read_only),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_status      (rsp.status),
    .out_handle      (rsp.result_handle),
    .out_object      (rsp.result_object),
    .out_type        (rsp.result_type),
    .out_flags       (rsp.result_flags),
    .out_read_only   (rsp.result_read_only)
  );

endmodule
`default_nettype wire

/* hw/rtl/hht_ctrl.sv */
// control state machine of the handle table
`timescale 1ns / 1ps
`default_nettype none
`include "hierarchical_handle_table_assert.svh"
module hht_ctrl import hht_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t st,
  output dp_cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = ST_OK;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (st.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.is_open) begin
          if (st.obj_zero) begin
            cmd.set_code = 1'b1;
            cmd.code     = ST_NULL;
            state_next   = S_RESP;
          end else begin
            cmd.top_init = 1'b1;
            state_next   = S_TOP;
          end
        end else begin
          cmd.addr_req = 1'b1;
          state_next   = S_RD_WAIT;
        end
      end
      S_RD_WAIT: state_next = S_EXEC;
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_RESP;
      end
      S_TOP: begin
        if (st.top_ok) begin
          cmd.top_take = 1'b1;
          state_next   = S_SUB;
        end else if (st.top_last) begin
          cmd.set_code = 1'b1;
          cmd.code     = ST_FULL;
          state_next   = S_RESP;
        end else begin
          cmd.top_next = 1'b1;
        end
      end
      S_SUB: begin
        if (st.sub_ok) begin
          cmd.sub_take = 1'b1;
          state_next   = S_LEAF_WAIT;
        end else if (st.sub_last) begin
          cmd.set_code = 1'b1;
          cmd.code     = ST_FULL;
          state_next   = S_RESP;
        end else begin
          cmd.sub_next = 1'b1;
        end
      end
      S_LEAF_WAIT: state_next = S_LEAF_CHK;
      S_LEAF_CHK: begin
        if (st.leaf_free) begin
          cmd.open_write = 1'b1;
          state_next     = S_RESP;
        end else if (st.leaf_last) begin
          cmd.set_code = 1'b1;
          cmd.code     = ST_FULL;
          state_next   = S_RESP;
        end else begin
          cmd.leaf_next = 1'b1;
          state_next    = S_LEAF_WAIT;
        end
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  `HHT_ASSERT_NEXT(a_clear_holds, (state == S_CLEAR) && !st.clear_last, state == S_CLEAR, "clear pass left early")
  `HHT_ASSERT_NEXT(a_resp_waits, (state == S_RESP) && !st.out_free, state == S_RESP, "result dropped")
  `HHT_ASSERT_NEXT(a_full_resp, (state == S_TOP) && !st.top_ok && st.top_last, state == S_RESP, "full scan did not end")

endmodule
`default_nettype wire

/* hw/rtl/hht_dp.sv */
// datapath of the handle table: slot memory, occupancy counts, scan counters, result
`timescale 1ns / 1ps
`default_nettype none
module hht_dp import hht_pkg::*; #(
  parameter int TOP_GROUPS = 8,
  parameter int SUB_GROUPS = 8,
  parameter int LEAF_SLOTS = 16,
  parameter int HOLD_BITS  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               st,
  input  wire logic [REQ_W-1:0]  in_req_type,
  input  wire logic [IDX_W-1:0]  in_handle_index,
  input  wire logic [TYPE_W-1:0] in_type_mask,
  input  wire logic [OBJ_W-1:0]  in_object_ref,
  input  wire logic [FLAG_W-1:0] in_entry_flags,
  input  wire logic              in_read_only,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [STAT_W-1:0]      out_status,
  output logic [IDX_W-1:0]       out_handle,
  output logic [OBJ_W-1:0]       out_object,
  output logic [TYPE_W-1:0]      out_type,
  output logic [FLAG_W-1:0]      out_flags,
  output logic                   out_read_only
);

  localparam int GROUP_SLOTS = SUB_GROUPS * LEAF_SLOTS;
  localparam int TOTAL       = TOP_GROUPS * GROUP_SLOTS;
  localparam int NSG         = TOP_GROUPS * SUB_GROUPS;
  localparam int AW          = $clog2(TOTAL);
  localparam int TW          = $clog2(TOP_GROUPS);
  localparam int SGW         = $clog2(NSG);
  localparam int SW          = (SUB_GROUPS > 1) ? $clog2(SUB_GROUPS) : 1;
  localparam int LW          = (LEAF_SLOTS > 1) ? $clog2(LEAF_SLOTS) : 1;
  localparam int CTW         = $clog2(GROUP_SLOTS + 1);
  localparam int CSW         = $clog2(LEAF_SLOTS + 1);
  localparam int HW          = AW + IDX_W;

  typedef struct packed {
    logic [TW-1:0]        top;
    logic [SGW-1:0]       sg;
    logic                 ro;
    logic                 closing;
    logic [HOLD_BITS-1:0] hold;
    logic [FLAG_W-1:0]    flags;
    logic [TYPE_W-1:0]    typ;
    logic [OBJ_W-1:0]     obj;
  } rec_t;

  rec_t mem [TOTAL];
  rec_t rd_data;
  rec_t mem_wd;
  logic mem_we;

  logic [REQ_W-1:0]  rq_type;
  logic [IDX_W-1:0]  rq_handle;
  logic [TYPE_W-1:0] rq_mask;
  logic [OBJ_W-1:0]  rq_obj;
  logic [FLAG_W-1:0] rq_flags;
  logic              rq_ro;

  logic [AW-1:0]  addr;
  logic [TW-1:0]  top;
  logic [SGW-1:0] sg;
  logic [SW-1:0]  sub;
  logic [LW-1:0]  leaf;

  logic [CTW-1:0] top_cnt [TOP_GROUPS];
  logic [CSW-1:0] sub_cnt [NSG];
  logic [CSW-1:0] sub_rd;
  logic [SGW-1:0] sub_ra;
  logic [SGW-1:0] dec_sg;
  logic           dec_pend;

  logic [STAT_W-1:0] resp_status;
  logic [IDX_W-1:0]  resp_handle;
  logic [OBJ_W-1:0]  resp_object;
  logic [TYPE_W-1:0] resp_type;
  logic [FLAG_W-1:0] resp_flags;
  logic              resp_ro;

  logic [HW-1:0] hwide;
  logic [HW-1:0] awide;
  logic          in_range;
  logic          occupied;
  logic          type_hit;

  status_code_t ex_status;
  logic         ex_we;
  rec_t         ex_rec;
  logic         ex_put;
  logic         ex_put_ro;
  logic         ex_dec;
  rec_t         open_rec;

  assign hwide    = HW'(rq_handle);
  assign awide    = HW'(addr);
  assign in_range = hwide < HW'(TOTAL);
  assign occupied = rd_data.obj != '0;
  assign type_hit = (rd_data.typ & rq_mask) != '0;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      rq_type   <= in_req_type;
      rq_handle <= in_handle_index;
      rq_mask   <= in_type_mask;
      rq_obj    <= in_object_ref;
      rq_flags  <= in_entry_flags;
      rq_ro     <= in_read_only;
    end
  end

  always_comb begin
    ex_status = ST_NOT_FOUND;
    ex_we     = 1'b0;
    ex_rec    = rd_data;
    ex_put    = 1'b0;
    ex_put_ro = 1'b0;
    ex_dec    = 1'b0;
    case (rq_type)
      REQ_USE, REQ_RCLOSE: begin
        if (in_range && (rq_handle != '0) && occupied && type_hit) begin
          if (rq_type == REQ_USE) begin
            if (rd_data.closing) begin
              ex_status = ST_CLOSING;
            end else begin
              ex_status = ST_OK;
              ex_put    = 1'b1;
              ex_put_ro = 1'b1;
              ex_we     = 1'b1;
              if (rd_data.hold != '1) ex_rec.hold = rd_data.hold + 1'b1;
            end
          end else begin
            if (rd_data.hold != '0) begin
              ex_status = ST_HELD;
            end else begin
              ex_status      = ST_OK;
              ex_put         = 1'b1;
              ex_put_ro      = 1'b1;
              ex_we          = 1'b1;
              ex_rec.closing = 1'b1;
            end
          end
        end
      end
      REQ_COMPLETE: begin
        if (rq_obj == '0) begin
          ex_status = ST_NULL;
        end else if (in_range) begin
          ex_status = ST_OK;
          ex_we     = 1'b1;
          if (rd_data.hold != '0) ex_rec.hold = rd_data.hold - 1'b1;
        end
      end
      REQ_CLOSE: begin
        if (in_range && occupied) begin
          ex_status = ST_OK;
          ex_put    = 1'b1;
          ex_we     = 1'b1;
          ex_dec    = 1'b1;
          ex_rec    = '0;
        end
      end
      default: ex_status = ST_NOT_FOUND;
    endcase
  end

  always_comb begin
    open_rec         = '0;
    open_rec.top     = top;
    open_rec.sg      = sg;
    open_rec.ro      = rq_ro;
    open_rec.flags   = rq_flags;
    open_rec.typ     = rq_mask;
    open_rec.obj     = rq_obj;
    mem_we           = 1'b0;
    mem_wd           = '0;
    if (cmd.clear_wr) begin
      mem_we = 1'b1;
    end else if (cmd.open_write) begin
      mem_we = 1'b1;
      mem_wd = open_rec;
    end else if (cmd.exec && ex_we) begin
      mem_we = 1'b1;
      mem_wd = ex_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= mem_wd;
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
      top  <= '0;
      sg   <= '0;
      sub  <= '0;
      leaf <= '0;
    end else begin
      if (cmd.clear_wr) addr <= addr + 1'b1;
      if (cmd.addr_req) addr <= hwide[AW-1:0];
      if (cmd.top_init) top <= TW'(1);
      if (cmd.top_next) top <= top + 1'b1;
      if (cmd.top_take) begin
        sg  <= SGW'(top) * SGW'(SUB_GROUPS);
        sub <= '0;
      end
      if (cmd.sub_next) begin
        sg  <= sg + 1'b1;
        sub <= sub + 1'b1;
      end
      if (cmd.sub_take) begin
        addr <= AW'(sg) * AW'(LEAF_SLOTS);
        leaf <= '0;
      end
      if (cmd.leaf_next) begin
        addr <= addr + 1'b1;
        leaf <= leaf + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TOP_GROUPS; i++) top_cnt[i] <= '0;
    end else if (cmd.open_write) begin
      top_cnt[top] <= top_cnt[top] + 1'b1;
    end else if (cmd.exec && ex_dec) begin
      if (top_cnt[rd_data.top] != '0) top_cnt[rd_data.top] <= top_cnt[rd_data.top] - 1'b1;
    end
  end

  // subgroup count read address follows the next scan position, or the subgroup of the executed record
  always_comb begin
    sub_ra = sg;
    if (cmd.exec) begin
      sub_ra = rd_data.sg;
    end else if (cmd.top_take) begin
      sub_ra = SGW'(top) * SGW'(SUB_GROUPS);
    end else if (cmd.sub_next) begin
      sub_ra = sg + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_pend <= 1'b0;
    end else begin
      dec_pend <= cmd.exec && ex_dec;
    end
    if (cmd.exec) dec_sg <= rd_data.sg;
  end

  always_ff @(posedge clk) begin
    sub_rd <= sub_cnt[sub_ra];
    if (cmd.clear_wr) begin
      if (awide < HW'(NSG)) sub_cnt[addr[SGW-1:0]] <= '0;
    end else if (cmd.open_write) begin
      sub_cnt[sg] <= sub_rd + 1'b1;
    end else if (dec_pend && (sub_rd != '0)) begin
      sub_cnt[dec_sg] <= sub_rd - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_code) begin
      resp_status <= cmd.code;
      resp_handle <= '0;
      resp_object <= '0;
      resp_type   <= '0;
      resp_flags  <= '0;
      resp_ro     <= 1'b0;
    end else if (cmd.open_write) begin
      resp_status <= ST_OK;
      resp_handle <= awide[IDX_W-1:0];
      resp_object <= '0;
      resp_type   <= '0;
      resp_flags  <= '0;
      resp_ro     <= 1'b0;
    end else if (cmd.exec) begin
      resp_status <= ex_status;
      resp_handle <= '0;
      resp_object <= ex_put ? rd_data.obj : '0;
      resp_type   <= ex_put ? rd_data.typ : '0;
      resp_flags  <= ex_put ? rd_data.flags : '0;
      resp_ro     <= ex_put_ro & rd_data.ro;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status    <= resp_status;
      out_handle    <= resp_handle;
      out_object    <= resp_object;
      out_type      <= resp_type;
      out_flags     <= resp_flags;
      out_read_only <= resp_ro;
    end
  end

  always_comb begin
    st.clear_last = addr == AW'(TOTAL - 1);
    st.is_open    = rq_type == REQ_OPEN;
    st.obj_zero   = rq_obj == '0;
    st.top_ok     = top_cnt[top] < CTW'(GROUP_SLOTS);
    st.top_last   = top == TW'(TOP_GROUPS - 1);
    st.sub_ok     = sub_rd < CSW'(LEAF_SLOTS);
    st.sub_last   = sub == SW'(SUB_GROUPS - 1);
    st.leaf_free  = rd_data.obj == '0;
    st.leaf_last  = leaf == LW'(LEAF_SLOTS - 1);
    st.out_free   = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

/* dv/hierarchical_handle_table_tb.sv */
// testbench for the hierarchical handle table: scoreboard, stimulus and result checks
`timescale 1ns / 1ps
`default_nettype none
module hierarchical_handle_table_tb;
  import hht_pkg::*;

  localparam int TOPS = 8;
  localparam int SUBS = 8;
  localparam int LEAVES = 16;
  localparam int NSLOTS = TOPS * SUBS * LEAVES;
  localparam int HOLD_MAX = 65535;

  typedef struct {
    status_code_t      status;
    logic [IDX_W-1:0]  handle;
    logic [OBJ_W-1:0]  obj;
    logic [TYPE_W-1:0] kind;
    logic [FLAG_W-1:0] flags;
    logic              ro;
  } table_result_t;

  class table_scoreboard;
    logic [OBJ_W-1:0]  obj_mem [NSLOTS];
    logic [TYPE_W-1:0] type_mem [NSLOTS];
    logic [FLAG_W-1:0] flag_mem [NSLOTS];
    int                hold_mem [NSLOTS];
    bit                closing_mem [NSLOTS];
    bit                ro_mem [NSLOTS];
    int                top_cnt [TOPS];
    int                sub_cnt [TOPS*SUBS];
    table_result_t     pending [$];
    int                errors;
    int                live [$];

    function new();
      for (int i = 0; i < NSLOTS; i++) begin
        obj_mem[i] = 0; type_mem[i] = 0; flag_mem[i] = 0;
        hold_mem[i] = 0; closing_mem[i] = 0; ro_mem[i] = 0;
      end
      foreach (top_cnt[i]) top_cnt[i] = 0;
      foreach (sub_cnt[i]) sub_cnt[i] = 0;
      errors = 0;
    endfunction

    function void note_request(req_code_t op, int idx, logic [TYPE_W-1:0] mask,
                               logic [OBJ_W-1:0] obj, logic [FLAG_W-1:0] flags, bit ro);
      table_result_t r;
      int t, s, l, slot;
      r = '{ST_NOT_FOUND, 0, 0, 0, 0, 0};
      case (op)
        REQ_OPEN: begin
          if (obj == 0) r.status = ST_NULL;
          else begin
            for (t = 1; t < TOPS; t++) if (top_cnt[t] < SUBS*LEAVES) break;
            if (t >= TOPS) r.status = ST_FULL;
            else begin
              for (s = 0; s < SUBS; s++) if (sub_cnt[t*SUBS+s] < LEAVES) break;
              if (s >= SUBS) r.status = ST_FULL;
              else begin
                for (l = 0; l < LEAVES; l++) if (obj_mem[(t*SUBS+s)*LEAVES+l] == 0) break;
                if (l >= LEAVES) r.status = ST_FULL;
                else begin
                  slot = (t*SUBS+s)*LEAVES+l;
                  top_cnt[t]++; sub_cnt[t*SUBS+s]++;
                  obj_mem[slot] = obj; type_mem[slot] = mask; flag_mem[slot] = flags;
                  ro_mem[slot] = ro; hold_mem[slot] = 0; closing_mem[slot] = 0;
                  r.status = ST_OK; r.handle = IDX_W'(slot);
                  live.push_back(slot);
                end
              end
            end
          end
        end
        REQ_USE, REQ_RCLOSE: begin
          if (idx < NSLOTS && idx != 0 && obj_mem[idx] != 0 && (type_mem[idx] & mask) != 0)
          begin
            if (op == REQ_USE && closing_mem[idx]) r.status = ST_CLOSING;
            else if (op == REQ_RCLOSE && hold_mem[idx] != 0) r.status = ST_HELD;
            else begin
              if (op == REQ_USE) begin
                if (hold_mem[idx] < HOLD_MAX) hold_mem[idx]++;
              end else closing_mem[idx] = 1;
              r = '{ST_OK, 0, obj_mem[idx], type_mem[idx], flag_mem[idx], ro_mem[idx]};
            end
          end
        end
        REQ_COMPLETE: begin
          if (obj == 0) r.status = ST_NULL;
          else if (idx < NSLOTS) begin
            if (hold_mem[idx] != 0) hold_mem[idx]--;
            r.status = ST_OK;
          end
        end
        REQ_CLOSE: begin
          if (idx < NSLOTS && obj_mem[idx] != 0) begin
            r = '{ST_OK, 0, obj_mem[idx], type_mem[idx], flag_mem[idx], 0};
            if (top_cnt[idx/(SUBS*LEAVES)] != 0) top_cnt[idx/(SUBS*LEAVES)]--;
            if (sub_cnt[idx/LEAVES] != 0) sub_cnt[idx/LEAVES]--;
            obj_mem[idx] = 0; type_mem[idx] = 0; flag_mem[idx] = 0;
            hold_mem[idx] = 0; closing_mem[idx] = 0; ro_mem[idx] = 0;
            foreach (live[i]) if (live[i] == idx) begin live.delete(i); break; end
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(table_result_t got);
      table_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result, status %0d", got.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d actual %0d", e.status, got.status); errors++;
      end
      if (got.handle !== e.handle) begin
        $error("result_handle: expected %0d actual %0d", e.handle, got.handle); errors++;
      end
      if (got.obj !== e.obj) begin
        $error("result_object: expected %h actual %h", e.obj, got.obj); errors++;
      end
      if (got.kind !== e.kind) begin
        $error("result_type: expected %h actual %h", e.kind, got.kind); errors++;
      end
      if (got.flags !== e.flags) begin
        $error("result_flags: expected %h actual %h", e.flags, got.flags); errors++;
      end
      if (got.ro !== e.ro) begin
        $error("result_read_only: expected %0d actual %0d", e.ro, got.ro); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  hht_req_if req ();
  hht_rsp_if rsp ();

  hierarchical_handle_table uut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  table_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;

  initial begin
    req.valid = 0; req.req_type = REQ_OPEN; req.handle_index = 0; req.type_mask = 0;
    req.object_ref = 0; req.entry_flags = 0; req.read_only = 0;
    rsp.ready = 0;
  end

  always @(posedge clk) begin
    if (rst) rsp.ready <= 0;
    else if (hold_off > 0) begin
      rsp.ready <= 0;
      hold_off <= hold_off - 1;
    end else rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst && rsp.valid && rsp.ready)
      sb.check_result('{status_code_t'(rsp.status), rsp.result_handle, rsp.result_object,
                        rsp.result_type, rsp.result_flags, rsp.result_read_only});
  end

  task automatic send_request(req_code_t op, int idx, logic [TYPE_W-1:0] mask,
                              logic [OBJ_W-1:0] obj, logic [FLAG_W-1:0] flags, bit ro);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1; req.req_type <= op; req.handle_index <= IDX_W'(idx);
    req.type_mask <= mask;
    req.object_ref <= obj; req.entry_flags <= flags; req.read_only <= ro;
    do @(posedge clk); while (!req.ready);
    sb.note_request(op, idx, mask, obj, flags, ro);
  endtask

  function automatic logic [OBJ_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_slot();
    if (sb.live.size() != 0 && $urandom_range(9) < 8)
      return sb.live[$urandom_range(sb.live.size()-1)];
    return $urandom_range(1023);
  endfunction

  task automatic random_request();
    int sel, idx;
    logic [TYPE_W-1:0] onehot;
    sel = $urandom_range(99);
    idx = pick_slot();
    onehot = 9'd1 << $urandom_range(8);
    if (sel < 30)
      send_request(REQ_OPEN, 0, ($urandom_range(9) == 0) ? 9'($urandom) : onehot,
                   ($urandom_range(19) == 0) ? 64'd0 : rand_word(), rand_word(),
                   $urandom_range(1));
    else if (sel < 55)
      send_request(REQ_USE, idx, ($urandom_range(3) == 0) ? 9'($urandom) : 9'h1ff,
                   rand_word(), rand_word(), $urandom_range(1));
    else if (sel < 70)
      send_request(REQ_COMPLETE, idx, 9'($urandom),
                   ($urandom_range(9) == 0) ? 64'd0 : rand_word(), rand_word(),
                   $urandom_range(1));
    else if (sel < 80)
      send_request(REQ_RCLOSE, idx, ($urandom_range(3) == 0) ? 9'($urandom) : 9'h1ff,
                   rand_word(), rand_word(), $urandom_range(1));
    else if (sel < 98)
      send_request(REQ_CLOSE, idx, 9'($urandom), rand_word(), rand_word(),
                   $urandom_range(1));
    else
      send_request(req_code_t'($urandom_range(5, 7)), idx, 9'($urandom), rand_word(),
                   rand_word(), $urandom_range(1));
  endtask

  initial begin
    int waited;
    repeat (8) @(posedge clk);
    rst <= 0;
    // directed
    send_request(REQ_OPEN, 0, 9'h001, 64'd0, 64'd0, 0);
    send_request(REQ_OPEN, 0, 9'h100, '1, '1, 1);
    send_request(REQ_OPEN, 0, 9'h001, 64'd1, 64'd0, 0);
    send_request(REQ_USE, 128, 9'h0ff, 0, 0, 0);
    send_request(REQ_USE, 128, 9'h100, 0, 0, 0);
    send_request(REQ_RCLOSE, 128, 9'h1ff, 0, 0, 0);
    send_request(REQ_COMPLETE, 128, 0, 64'd0, 0, 0);
    send_request(REQ_COMPLETE, 128, 0, 64'd5, 0, 0);
    send_request(REQ_COMPLETE, 128, 0, 64'd5, 0, 0);
    send_request(REQ_RCLOSE, 128, 9'h1ff, 0, 0, 0);
    send_request(REQ_USE, 128, 9'h1ff, 0, 0, 0);
    send_request(REQ_USE, 0, 9'h1ff, 0, 0, 0);
    send_request(REQ_USE, 1023, 9'h1ff, 0, 0, 0);
    send_request(REQ_CLOSE, 1023, 0, 0, 0, 0);
    send_request(REQ_COMPLETE, 1023, 0, 64'd3, 0, 0);
    send_request(REQ_CLOSE, 128, 0, 0, 0, 0);
    send_request(REQ_CLOSE, 128, 0, 0, 0, 0);
    send_request(REQ_CLOSE, 129, 0, 0, 0, 0);
    send_request(req_code_t'(3'd7), 5, 0, 0, 0, 0);
    // reopen a slot and take a hold on it
    send_request(REQ_OPEN, 0, 9'h002, 64'h77, 64'h1, 0);
    send_request(REQ_USE, 128, 9'h002, 0, 0, 0);
    // fill the table to reach full
    send_idle_pct = 0; recv_idle_pct = 0;
    while (sb.live.size() < NSLOTS - 128)
      send_request(REQ_OPEN, 0, 9'h1 << $urandom_range(8), rand_word(), rand_word(),
                   $urandom_range(1));
    send_request(REQ_OPEN, 0, 9'h004, 64'h9, 0, 0);
    for (int i = 0; i < 300; i++) send_request(REQ_CLOSE, pick_slot(), 0, 0, 0, 0);
    // random phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 87 : 0;
      recv_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 22 : 0;
      if (ph == 2) hold_off = 400;
      for (int i = 0; i < 145; i++) random_request();
    end
    req.valid <= 1'b0;
    waited = 0;
    while (sb.pending.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (sb.pending.size() == 0 && sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
